### rtl/core/ldf_pkg.sv
// Package for the length-prefixed UTF-8 deframer core.
// Holds the phase and result-kind types, the result record and character constants.
// No dependencies.
`timescale 1ns / 1ps

package ldf_pkg;

    localparam int ACC_W      = 27;
    localparam int FIFO_DEPTH = 2;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] LEAD3    = 8'hE0;
    localparam logic [7:0] LEAD2    = 8'hC0;
    localparam logic [7:0] MASK3    = 8'h0F;
    localparam logic [7:0] MASK2    = 8'h1F;
    localparam logic [7:0] MASKC    = 8'h3F;

    typedef enum logic [1:0] {
        PH_LEN = 2'd0,
        PH_PAY = 2'd1,
        PH_SEP = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_UNIT     = 2'd0,
        KIND_END      = 2'd1,
        KIND_TOO_LONG = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] code_unit;
        logic        truncated;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_push;

endpackage

### rtl/core/ldf_if.sv
// Stream interfaces for the deframer: raw byte input and decoded result output.
// Depends on ldf_pkg.
`timescale 1ns / 1ps

interface ldf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface ldf_result_if;
    logic           valid;
    logic           ready;
    ldf_pkg::t_kind kind;
    logic [15:0]    code_unit;
    logic           truncated;

    modport source (output valid, output kind, output code_unit, output truncated, input ready);
    modport sink   (input valid, input kind, input code_unit, input truncated, output ready);
endinterface

### rtl/core/ldf_front.sv
// Front end: parses the length field, walks payload bytes, decodes UTF-8 units.
// Produces at most one result per accepted byte. Depends on ldf_pkg, ldf_if.
`timescale 1ns / 1ps

module ldf_front #(
    parameter int MAX_FIELD_CHARS = 9
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ldf_byte_if.sink        i_byte,
    input  logic            i_space,
    output ldf_pkg::t_push  o_push
);

    localparam int FC_W = $clog2(MAX_FIELD_CHARS + 1);
    localparam logic [FC_W-1:0] FC_MAX = FC_W'(MAX_FIELD_CHARS);
    localparam int AW = ldf_pkg::ACC_W;

    ldf_pkg::t_phase  r_phase, n_phase;
    logic [FC_W-1:0]  r_fc, n_fc;
    logic [AW-1:0]    r_acc, n_acc;
    logic             r_neg, n_neg;
    logic             r_stop, n_stop;
    logic [AW-1:0]    r_left, n_left;
    logic [1:0]       r_pend, n_pend;
    logic [15:0]      r_part, n_part;
    logic             r_closed, n_closed;

    logic             accept;
    logic [7:0]       b;
    logic             too_long, is_space, is_digit, neg_len;
    logic [AW+3:0]    mul10;
    logic [AW-1:0]    left_dec;
    logic             last;
    logic             emit_req, emit_trunc;
    logic [15:0]      emit_val;

    assign i_byte.ready = i_space;
    assign accept   = i_byte.valid & i_space;
    assign b        = i_byte.byte_in;
    assign too_long = (r_fc >= FC_MAX);
    assign is_space = (b == ldf_pkg::CH_SPACE);
    assign is_digit = (b >= ldf_pkg::CH_ZERO) && (b <= ldf_pkg::CH_NINE);
    assign neg_len  = r_neg && (r_acc != '0);
    assign mul10    = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0}
                    + {(AW - 4)'(0), (b - ldf_pkg::CH_ZERO)};
    assign left_dec = r_left - 1'b1;
    assign last     = (left_dec == '0);

    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            unique case (r_phase)
                ldf_pkg::PH_PAY: begin
                    if (last) n_phase = ldf_pkg::PH_SEP;
                end
                ldf_pkg::PH_SEP: begin
                    n_phase = ldf_pkg::PH_LEN;
                end
                default: begin
                    n_phase = ldf_pkg::PH_LEN;
                    if (!too_long && is_space && !neg_len) begin
                        n_phase = (r_acc == '0) ? ldf_pkg::PH_SEP : ldf_pkg::PH_PAY;
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_fc       = r_fc;
        n_acc      = r_acc;
        n_neg      = r_neg;
        n_stop     = r_stop;
        n_left     = r_left;
        n_pend     = r_pend;
        n_part     = r_part;
        n_closed   = r_closed;
        emit_req   = 1'b0;
        emit_val   = '0;
        emit_trunc = 1'b0;
        o_push     = '0;
        if (accept) begin
            unique case (r_phase)
                ldf_pkg::PH_PAY: begin
                    n_left = left_dec;
                    unique case (r_pend)
                        2'd0: begin
                            if (b >= ldf_pkg::LEAD3) begin
                                n_part = {b[3:0], 12'd0};
                                n_pend = 2'd2;
                            end else if (b >= ldf_pkg::LEAD2) begin
                                n_part = {5'd0, b[4:0], 6'd0};
                                n_pend = 2'd1;
                            end else begin
                                emit_req = 1'b1;
                                emit_val = {8'd0, b};
                            end
                            if (b >= ldf_pkg::LEAD2 && last) begin
                                n_pend   = 2'd0;
                                emit_req = 1'b1;
                                emit_val = '0;
                            end
                        end
                        2'd2: begin
                            n_part = r_part | {4'd0, b[5:0], 6'd0};
                            n_pend = 2'd1;
                            if (last) begin
                                emit_req   = 1'b1;
                                emit_val   = r_part | {4'd0, b[5:0], 6'd0};
                                emit_trunc = 1'b1;
                            end
                        end
                        default: begin
                            n_part   = r_part | {10'd0, b[5:0]};
                            n_pend   = 2'd0;
                            emit_req = 1'b1;
                            emit_val = r_part | {10'd0, b[5:0]};
                        end
                    endcase
                    if (last) n_pend = 2'd0;
                    if (emit_req && !r_closed) begin
                        if (emit_val == '0) begin
                            n_closed = 1'b1;
                        end else begin
                            o_push.valid         = 1'b1;
                            o_push.res.kind      = ldf_pkg::KIND_UNIT;
                            o_push.res.code_unit = emit_val;
                            o_push.res.truncated = emit_trunc;
                        end
                    end
                end
                ldf_pkg::PH_SEP: begin
                    n_closed = 1'b0;
                    n_pend   = 2'd0;
                    n_part   = '0;
                    n_fc     = '0;
                    n_acc    = '0;
                    n_neg    = 1'b0;
                    n_stop   = 1'b0;
                    o_push.valid    = 1'b1;
                    o_push.res.kind = ldf_pkg::KIND_END;
                end
                default: begin
                    if (too_long) begin
                        n_fc   = '0;
                        n_acc  = '0;
                        n_neg  = 1'b0;
                        n_stop = 1'b0;
                        o_push.valid    = 1'b1;
                        o_push.res.kind = ldf_pkg::KIND_TOO_LONG;
                    end else if (is_space) begin
                        n_fc     = '0;
                        n_acc    = '0;
                        n_neg    = 1'b0;
                        n_stop   = 1'b0;
                        n_pend   = 2'd0;
                        n_part   = '0;
                        n_closed = 1'b0;
                        if (neg_len) begin
                            o_push.valid    = 1'b1;
                            o_push.res.kind = ldf_pkg::KIND_END;
                        end else begin
                            n_left = r_acc;
                        end
                    end else begin
                        if (r_fc == '0 && (b == ldf_pkg::CH_PLUS || b == ldf_pkg::CH_MINUS)) begin
                            n_neg = (b == ldf_pkg::CH_MINUS);
                        end else if (!r_stop && is_digit) begin
                            n_acc = (mul10 > {4'd0, ldf_pkg::ACC_MAX}) ? ldf_pkg::ACC_MAX
                                                                     : mul10[AW-1:0];
                        end else begin
                            n_stop = 1'b1;
                        end
                        n_fc = r_fc + 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= ldf_pkg::PH_LEN;
            r_fc     <= '0;
            r_acc    <= '0;
            r_neg    <= 1'b0;
            r_stop   <= 1'b0;
            r_left   <= '0;
            r_pend   <= 2'd0;
            r_part   <= '0;
            r_closed <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_fc     <= n_fc;
            r_acc    <= n_acc;
            r_neg    <= n_neg;
            r_stop   <= n_stop;
            r_left   <= n_left;
            r_pend   <= n_pend;
            r_part   <= n_part;
            r_closed <= n_closed;
        end
    end

endmodule

### rtl/core/ldf_queue.sv
// Result queue between the parser and the output channel; drives the output side.
// Depends on ldf_pkg, ldf_if.
`timescale 1ns / 1ps

module ldf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ldf_pkg::t_push i_push,
    output logic           o_space,
    ldf_result_if.source   o_result
);

    localparam int DEPTH = ldf_pkg::FIFO_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    ldf_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             push, pop;
    ldf_pkg::t_result head;

    assign o_space = (r_cnt != CNT_FULL);
    assign push    = i_push.valid & o_space;
    assign pop     = o_result.valid & o_result.ready;
    assign head    = r_mem[r_rd];

    assign o_result.valid     = (r_cnt != '0);
    assign o_result.kind      = head.kind;
    assign o_result.code_unit = head.code_unit;
    assign o_result.truncated = head.truncated;

    always_comb begin
        n_wr  = push ? PW'((32'(r_wr) + 1) % DEPTH) : r_wr;
        n_rd  = pop  ? PW'((32'(r_rd) + 1) % DEPTH) : r_rd;
        n_cnt = r_cnt + CW'(push) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_push.res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

### rtl/core/length_prefixed_utf8_param_deframer_core.sv
// Top level of the length-prefixed UTF-8 parameter deframer.
// Depends on ldf_pkg, ldf_if, ldf_front, ldf_queue.
//
// Usage:
//   i_byte   : raw stream bytes, one per transaction (valid/ready).
//   o_result : decoded records (kind, code_unit, truncated), one per transaction.
//   A length field "<sign><digits> " precedes each parameter; the payload is
//   decoded into 16-bit units (kind 0), the separator or a negative length's space
//   gives kind 1, over-long length fields kind 2; bytes completing nothing give none.
// Timing:
//   One input byte per cycle while the queue has space. Each record is registered
//   into the queue when its byte is accepted and leaves in order; parser state is registered.
//   A two-entry queue sits between the parser and the output, so input keeps
//   flowing while a record waits; i_byte.ready drops only when the queue is full.
// Reset:
//   Synchronous, active low; parser returns to the length field phase and the
//   queue empties. No memory clearing is needed.
`timescale 1ns / 1ps

module length_prefixed_utf8_param_deframer_core #(
    parameter int MAX_FIELD_CHARS = 9
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ldf_byte_if.sink     i_byte,
    ldf_result_if.source o_result
);

    ldf_pkg::t_push push;
    logic           space;

    ldf_front #(
        .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_space (space),
        .o_push  (push)
    );

    ldf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_space  (space),
        .o_result (o_result)
    );

endmodule

### rtl/core/ldf_checker.sv
// Port-level checks for the deframer top level, attached by bind.
// Depends on ldf_pkg and length_prefixed_utf8_param_deframer_core.
`timescale 1ns / 1ps

module ldf_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input ldf_pkg::t_kind i_kind,
    input logic [15:0]    i_code_unit,
    input logic           i_truncated
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_unit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_kind == ldf_pkg::KIND_UNIT) |-> (i_code_unit != 16'd0))
        else $error("zero code unit reported");

    a_ctrl_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_kind != ldf_pkg::KIND_UNIT) |-> (i_code_unit == 16'd0 && !i_truncated))
        else $error("control record carries unit data");

    a_trunc_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_truncated) |-> (i_code_unit[5:0] == 6'd0))
        else $error("truncated unit has nonzero last byte bits");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_code_unit)))
        else $error("stalled record changed");

endmodule

bind length_prefixed_utf8_param_deframer_core ldf_checker u_ldf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_kind      (o_result.kind),
    .i_code_unit (o_result.code_unit),
    .i_truncated (o_result.truncated)
);
